@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property at every rising edge, including during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ sv/dmtm_pkg.sv @@
// ----------------------------------------------------------------------------
// Display mode timeout manager package
// Mode codes, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dmtm_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WAKE    = 3'd1,
        MODE_LISTEN  = 3'd2,
        MODE_THINK   = 3'd3,
        MODE_ACTION  = 3'd4,
        MODE_ERROR   = 3'd5,
        MODE_SLEEP   = 3'd6,
        MODE_UNKNOWN = 3'd7
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LISTEN_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THINK_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_OFF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 3'd5;

    localparam logic [CFG_W-1:0] RST_SHORT_TIMEOUT  = 16'd2000;
    localparam logic [CFG_W-1:0] RST_LISTEN_TIMEOUT = 16'd5000;
    localparam logic [CFG_W-1:0] RST_THINK_TIMEOUT  = 16'd8000;
    localparam logic [CFG_W-1:0] RST_SLEEP_TIMEOUT  = 16'd6000;
    localparam logic [CFG_W-1:0] RST_SLEEP_OFF      = 16'd5000;
    localparam logic [CFG_W-1:0] RST_IDLE_TIMEOUT   = 16'd30000;

    typedef struct packed {
        logic [CFG_W-1:0] short_timeout;
        logic [CFG_W-1:0] listen_timeout;
        logic [CFG_W-1:0] think_timeout;
        logic [CFG_W-1:0] sleep_timeout;
        logic [CFG_W-1:0] sleep_off_delay;
        logic [CFG_W-1:0] idle_timeout;
    } t_cfg;

    // Timeout that returns a mode to idle; zero means none.
    function automatic logic [CFG_W-1:0] mode_limit(t_mode m, t_cfg c);
        logic [CFG_W-1:0] lim;
        lim = '0;
        case (m)
            MODE_WAKE, MODE_ACTION, MODE_ERROR: lim = c.short_timeout;
            MODE_LISTEN:                        lim = c.listen_timeout;
            MODE_THINK:                         lim = c.think_timeout;
            MODE_SLEEP:                         lim = c.sleep_timeout;
            default:                            lim = '0;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

@@ sv/dmtm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration register file
// Six 16-bit timeout registers; writes to indexes past the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dmtm_cfg_regs import dmtm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_timeout   <= RST_SHORT_TIMEOUT;
            r_cfg.listen_timeout  <= RST_LISTEN_TIMEOUT;
            r_cfg.think_timeout   <= RST_THINK_TIMEOUT;
            r_cfg.sleep_timeout   <= RST_SLEEP_TIMEOUT;
            r_cfg.sleep_off_delay <= RST_SLEEP_OFF;
            r_cfg.idle_timeout    <= RST_IDLE_TIMEOUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SHORT_TIMEOUT:  r_cfg.short_timeout   <= i_cfg_data;
                REG_LISTEN_TIMEOUT: r_cfg.listen_timeout  <= i_cfg_data;
                REG_THINK_TIMEOUT:  r_cfg.think_timeout   <= i_cfg_data;
                REG_SLEEP_TIMEOUT:  r_cfg.sleep_timeout   <= i_cfg_data;
                REG_SLEEP_OFF:      r_cfg.sleep_off_delay <= i_cfg_data;
                REG_IDLE_TIMEOUT:   r_cfg.idle_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/dmtm_core.sv @@
// ----------------------------------------------------------------------------
// Mode and timeout core
// Holds mode, power flag and elapsed counters; applies one transaction per
// cycle unless a held result is stalled, and keeps the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dmtm_core import dmtm_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_in_valid,
    input  wire logic i_op,
    input  wire t_mode i_new_mode,
    output logic      o_take,
    input  wire logic i_out_stall,
    output logic      o_out_valid,
    output logic [2:0] o_mode,
    output logic      o_display_on,
    output logic      o_power_up,
    output logic      o_power_down,
    output logic      o_anim_restart
);

    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    t_mode                 r_mode, n_mode;
    logic                  r_power, n_power;
    logic [COUNT_BITS-1:0] r_since_entry, n_since_entry;
    logic [COUNT_BITS-1:0] r_since_act, n_since_act;
    logic [COUNT_BITS-1:0] se_inc, sa_inc;
    logic [CFG_W-1:0]      limit;
    logic                  n_up, n_down, n_anim;

    logic                  r_out_valid;
    t_mode                 r_res_mode;
    logic                  r_res_power, r_res_up, r_res_down, r_res_anim;

    assign o_take = i_in_valid && (!r_out_valid || !i_out_stall);

    // Saturating counters stop at all ones.
    assign se_inc = (&r_since_entry) ? r_since_entry : r_since_entry + 1'b1;
    assign sa_inc = (&r_since_act)   ? r_since_act   : r_since_act + 1'b1;
    assign limit  = mode_limit(r_mode, i_cfg);

    always_comb begin
        n_mode        = r_mode;
        n_power       = r_power;
        n_since_entry = r_since_entry;
        n_since_act   = r_since_act;
        n_up          = 1'b0;
        n_down        = 1'b0;
        n_anim        = 1'b0;
        if (i_op) begin
            n_mode        = i_new_mode;
            n_since_entry = '0;
            n_since_act   = '0;
            n_anim        = 1'b1;
            if (!r_power) begin
                n_power = 1'b1;
                n_up    = 1'b1;
            end
        end else begin
            n_since_entry = se_inc;
            n_since_act   = sa_inc;
            // Mode timeout back to idle.
            if (r_mode != MODE_IDLE && limit != '0 &&
                CMP_W'(se_inc) >= CMP_W'(limit)) begin
                n_mode      = MODE_IDLE;
                n_anim      = 1'b1;
                n_since_act = '0;
            end
            // Power down after the delay in sleeping.
            if (n_mode == MODE_SLEEP && r_power &&
                CMP_W'(se_inc) >= CMP_W'(i_cfg.sleep_off_delay)) begin
                n_power = 1'b0;
                n_down  = 1'b1;
            end
            // Idle too long with display on: go to sleeping.
            if (n_mode == MODE_IDLE && n_power &&
                CMP_W'(n_since_act) >= CMP_W'(i_cfg.idle_timeout)) begin
                n_mode        = MODE_SLEEP;
                n_anim        = 1'b1;
                n_since_entry = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_power       <= 1'b0;
            r_since_entry <= '0;
            r_since_act   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode        <= n_mode;
                r_power       <= n_power;
                r_since_entry <= n_since_entry;
                r_since_act   <= n_since_act;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res_mode  <= n_mode;
            r_res_power <= n_power;
            r_res_up    <= n_up;
            r_res_down  <= n_down;
            r_res_anim  <= n_anim;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mode         = r_res_mode;
    assign o_display_on   = r_res_power;
    assign o_power_up     = r_res_up;
    assign o_power_down   = r_res_down;
    assign o_anim_restart = r_res_anim;

    `ASSERT_CLK(a_event_sets_mode,
        o_take && i_op |=> o_out_valid && o_mode == $past(i_new_mode),
        "event transaction did not apply its mode")
    `ASSERT_CLK(a_down_in_sleep,
        o_out_valid && o_power_down |-> !o_display_on && o_mode == MODE_SLEEP,
        "power down outside sleeping or with display on")
    `ASSERT_CLK(a_up_restarts,
        o_out_valid && o_power_up |-> o_display_on && o_anim_restart,
        "power up without display on and animation restart")
    `ASSERT_CLK(a_state_holds,
        !o_take |=> $stable(r_since_entry) && $stable(r_since_act) && $stable(r_mode),
        "state changed without a transaction")

endmodule

`default_nettype wire

@@ sv/display_mode_timeout_manager.sv @@
// A transaction passes the input register, then the core's output register, to the outputs.
// Throughput: one transaction per cycle while the receiver does not stall the output.
// A stalled result holds in the output register while the input register
// still takes one more transaction.
// Reset (synchronous, active low): mode idle, display off, counters cleared,
// timeout registers at their defaults.
// ----------------------------------------------------------------------------
// Display mode timeout manager
// Input register, configuration registers and the mode/timeout core.
// ----------------------------------------------------------------------------
`default_nettype none

module display_mode_timeout_manager import dmtm_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_op,
    input  wire logic [2:0]           i_new_mode,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [2:0]                o_mode,
    output logic                      o_display_on,
    output logic                      o_power_up,
    output logic                      o_power_down,
    output logic                      o_anim_restart,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  cfg;
    logic  r_in_valid;
    logic  r_op;
    t_mode r_new_mode;
    logic  take;

    assign o_in_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op       <= i_op;
            r_new_mode <= t_mode'(i_new_mode);
        end
    end

    dmtm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dmtm_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (r_in_valid),
        .i_op           (r_op),
        .i_new_mode     (r_new_mode),
        .o_take         (take),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_mode         (o_mode),
        .o_display_on   (o_display_on),
        .o_power_up     (o_power_up),
        .o_power_down   (o_power_down),
        .o_anim_restart (o_anim_restart)
    );

endmodule

`default_nettype wire

@@ test/tb_display_mode_timeout_manager.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Display mode timeout manager testbench
// Directed table, then phases of random ticks and mode events under
// several register settings. Each result is checked against the table's
// expected status or a local model of the mode, power flag and elapsed
// counters. Sender bursts and receiver stalls vary along the run.
// ----------------------------------------------------------------------------

module tb_display_mode_timeout_manager import dmtm_pkg::*;;

    localparam int CNT_W       = 16;
    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_N       = 24;
    localparam int DIR_TYPED_N = 5;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 150;
    localparam int MAX_REPORTS = 10;

    localparam logic                  OP_TICK  = 1'b0;
    localparam logic                  OP_EVENT = 1'b1;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = 3'd7;
    localparam logic [CNT_W-1:0]      CNT_MAX = '1;

    typedef struct packed {
        t_mode mode;
        logic  display_on;
        logic  power_up;
        logic  power_down;
        logic  anim_restart;
    } t_status;

    typedef struct packed {
        logic    op;
        t_mode   new_mode;
        logic    typed;
        t_status want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 i_op = 1'b0;
    logic [2:0]           i_new_mode = 3'd0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [2:0]           o_mode;
    logic                 o_display_on;
    logic                 o_power_up;
    logic                 o_power_down;
    logic                 o_anim_restart;
    logic                 o_cfg_ready;

    display_mode_timeout_manager #(
        .COUNT_BITS(CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_new_mode    (i_new_mode),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mode        (o_mode),
        .o_display_on  (o_display_on),
        .o_power_up    (o_power_up),
        .o_power_down  (o_power_down),
        .o_anim_restart(o_anim_restart),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Model state: register copies, mode, power flag, elapsed counters.
    t_cfg             cfg_shadow;
    t_mode            m_mode;
    logic             m_disp;
    logic [CNT_W-1:0] m_entry;
    logic [CNT_W-1:0] m_activity;

    t_status pending_status [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;

    // Directed rows; the first ones run with the reset register values.
    t_row dir_rows [DIR_N] = '{
        '{OP_TICK,  MODE_SLEEP,   1'b1, '{MODE_IDLE,    1'b0, 1'b0, 1'b0, 1'b0}},
        '{OP_EVENT, MODE_IDLE,    1'b1, '{MODE_IDLE,    1'b1, 1'b1, 1'b0, 1'b1}},
        '{OP_EVENT, MODE_WAKE,    1'b1, '{MODE_WAKE,    1'b1, 1'b0, 1'b0, 1'b1}},
        '{OP_EVENT, MODE_UNKNOWN, 1'b1, '{MODE_UNKNOWN, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{OP_TICK,  MODE_WAKE,    1'b1, '{MODE_UNKNOWN, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{OP_EVENT, MODE_WAKE,    1'b0, '0},
        '{OP_TICK,  MODE_UNKNOWN, 1'b0, '0},
        '{OP_TICK,  MODE_LISTEN,  1'b0, '0},
        '{OP_TICK,  MODE_THINK,   1'b0, '0},
        '{OP_TICK,  MODE_IDLE,    1'b0, '0},
        '{OP_TICK,  MODE_ERROR,   1'b0, '0},
        '{OP_TICK,  MODE_ACTION,  1'b0, '0},
        '{OP_TICK,  MODE_SLEEP,   1'b0, '0},
        '{OP_TICK,  MODE_WAKE,    1'b0, '0},
        '{OP_TICK,  MODE_UNKNOWN, 1'b0, '0},
        '{OP_EVENT, MODE_SLEEP,   1'b0, '0},
        '{OP_EVENT, MODE_LISTEN,  1'b0, '0},
        '{OP_TICK,  MODE_IDLE,    1'b0, '0},
        '{OP_EVENT, MODE_THINK,   1'b0, '0},
        '{OP_TICK,  MODE_THINK,   1'b0, '0},
        '{OP_EVENT, MODE_ERROR,   1'b0, '0},
        '{OP_EVENT, MODE_ACTION,  1'b0, '0},
        '{OP_TICK,  MODE_SLEEP,   1'b0, '0},
        '{OP_TICK,  MODE_WAKE,    1'b0, '0}
    };

    function automatic logic [CFG_W-1:0] mode_timeout(t_mode m);
        case (m)
            MODE_WAKE, MODE_ACTION, MODE_ERROR: return cfg_shadow.short_timeout;
            MODE_LISTEN:                        return cfg_shadow.listen_timeout;
            MODE_THINK:                         return cfg_shadow.think_timeout;
            MODE_SLEEP:                         return cfg_shadow.sleep_timeout;
            default:                            return '0;
        endcase
    endfunction

    task automatic step_mode_state(input logic op, input t_mode nm, output t_status st);
        logic [CFG_W-1:0] lim;
        st = '0;
        if (op == OP_EVENT) begin
            m_mode = nm;
            m_entry = '0;
            m_activity = '0;
            st.anim_restart = 1'b1;
            if (!m_disp) begin
                m_disp = 1'b1;
                st.power_up = 1'b1;
            end
        end else begin
            if (m_entry != CNT_MAX) m_entry = m_entry + 1'b1;
            if (m_activity != CNT_MAX) m_activity = m_activity + 1'b1;
            if (m_mode != MODE_IDLE) begin
                lim = mode_timeout(m_mode);
                if (lim != '0 && m_entry >= lim) begin
                    m_mode = MODE_IDLE;
                    st.anim_restart = 1'b1;
                    m_activity = '0;
                end
            end
            if (m_mode == MODE_SLEEP && m_disp && m_entry >= cfg_shadow.sleep_off_delay) begin
                m_disp = 1'b0;
                st.power_down = 1'b1;
            end
            if (m_mode == MODE_IDLE && m_disp && m_activity >= cfg_shadow.idle_timeout) begin
                m_mode = MODE_SLEEP;
                st.anim_restart = 1'b1;
                m_entry = '0;
            end
        end
        st.mode = m_mode;
        st.display_on = m_disp;
    endtask

    // Send one transaction; gaps open only between bursts.
    task automatic drive_item(input logic op, input t_mode nm, input logic typed,
                              input t_status want);
        int      gap;
        t_status st;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_new_mode <= nm;
        do @(posedge i_clk); while (o_in_stall);
        step_mode_state(op, nm, st);
        pending_status.push_back(typed ? want : st);
    endtask

    // Leaves i_cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SHORT_TIMEOUT:  cfg_shadow.short_timeout = val;
            REG_LISTEN_TIMEOUT: cfg_shadow.listen_timeout = val;
            REG_THINK_TIMEOUT:  cfg_shadow.think_timeout = val;
            REG_SLEEP_TIMEOUT:  cfg_shadow.sleep_timeout = val;
            REG_SLEEP_OFF:      cfg_shadow.sleep_off_delay = val;
            REG_IDLE_TIMEOUT:   cfg_shadow.idle_timeout = val;
            default: ;
        endcase
    endtask

    // Hold off the sender and wait until every result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_cfg c);
        write_reg(REG_SHORT_TIMEOUT,  c.short_timeout);
        write_reg(REG_LISTEN_TIMEOUT, c.listen_timeout);
        write_reg(REG_THINK_TIMEOUT,  c.think_timeout);
        write_reg(REG_SLEEP_TIMEOUT,  c.sleep_timeout);
        write_reg(REG_SLEEP_OFF,      c.sleep_off_delay);
        write_reg(REG_IDLE_TIMEOUT,   c.idle_timeout);
        // Writes past the register list must not disturb anything.
        write_reg(REG_SPARE_LO, CFG_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_value(int style);
        case (style)
            0: return CFG_W'($urandom_range(1, 8));
            1: return '0;
            2: return '1;
            3: return CFG_W'($urandom_range(0, 30));
            5: return CFG_W'($urandom_range(0, 4));
            default: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return CFG_W'(1);
                    3: return CFG_W'($urandom_range(2, 12));
                    default: return CFG_W'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_cfg pick_setting(int style);
        t_cfg c;
        c.short_timeout   = pick_value(style);
        c.listen_timeout  = pick_value(style);
        c.think_timeout   = pick_value(style);
        c.sleep_timeout   = pick_value(style);
        c.sleep_off_delay = pick_value(style);
        c.idle_timeout    = pick_value(style);
        return c;
    endfunction

    // Receiver stall pattern: switch among four styles whenever the run counter runs out.
    int stall_style = 0;
    int stall_left  = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= (stall_left % 3 == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: mode=%0d on=%0b up=%0b down=%0b anim=%0b",
                             o_mode, o_display_on, o_power_up, o_power_down, o_anim_restart);
            end else begin
                want = pending_status.pop_front();
                if (o_mode !== want.mode || o_display_on !== want.display_on ||
                    o_power_up !== want.power_up || o_power_down !== want.power_down ||
                    o_anim_restart !== want.anim_restart) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $write("mismatch: expected mode=%0d on=%0b up=%0b down=%0b anim=%0b,",
                               want.mode, want.display_on, want.power_up,
                               want.power_down, want.anim_restart);
                        $display(" got mode=%0d on=%0b up=%0b down=%0b anim=%0b",
                                 o_mode, o_display_on, o_power_up, o_power_down,
                                 o_anim_restart);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_status.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int   ev_pct;
        logic op;
        t_cfg small_cfg;

        cfg_shadow = '{RST_SHORT_TIMEOUT, RST_LISTEN_TIMEOUT, RST_THINK_TIMEOUT,
                       RST_SLEEP_TIMEOUT, RST_SLEEP_OFF, RST_IDLE_TIMEOUT};
        m_mode     = MODE_IDLE;
        m_disp     = 1'b0;
        m_entry    = '0;
        m_activity = '0;
        small_cfg  = '{16'd2, 16'd3, 16'd1, 16'd4, 16'd2, 16'd3};

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++) begin
            // Short timeouts make the rest of the table walk every timed path.
            if (r == DIR_TYPED_N) begin
                drain_results();
                write_setting(small_cfg);
            end
            drive_item(dir_rows[r].op, dir_rows[r].new_mode, dir_rows[r].typed,
                       dir_rows[r].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            write_setting(pick_setting(ph));
            ev_pct = $urandom_range(5, 30);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < ev_pct) ? OP_EVENT : OP_TICK;
                drive_item(op, t_mode'($urandom_range(0, 7)), 1'b0, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
